/* design/ptw_pkg.sv */
// shared types, codes and constants of the two-level page walker
`default_nettype none

package ptw_pkg;

   // address layout
   localparam int unsigned PageShift = 12;
   localparam int unsigned PageSize  = 4096;
   localparam int unsigned VpnBits   = 10;

   // entry bit positions
   localparam int unsigned BitP = 0;
   localparam int unsigned BitW = 1;
   localparam int unsigned BitU = 2;
   localparam int unsigned BitA = 5;
   localparam int unsigned BitD = 6;

   // job queue depth between front and back
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   // result word kinds
   typedef enum logic [2:0] {
      KIND_MEM_READ  = 3'd0,
      KIND_MEM_WRITE = 3'd1,
      KIND_DONE      = 3'd2,
      KIND_FAULT     = 3'd3,
      KIND_CROSS     = 3'd4
   } out_kind_type;

   // access kinds
   localparam logic [1:0] AccFetch = 2'd0;
   localparam logic [1:0] AccRead  = 2'd1;
   localparam logic [1:0] AccWrite = 2'd2;

   // input operations
   localparam logic OpRequest  = 1'b0;
   localparam logic OpResponse = 1'b1;

   // walk phase
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_DIR  = 3'b010,
      PH_TBL  = 3'b100
   } phase_type;

   // job classes handed from front to back
   typedef enum logic [1:0] {
      JOB_CROSS = 2'd0,
      JOB_READ  = 2'd1,
      JOB_FAULT = 2'd2,
      JOB_LEAF  = 2'd3
   } job_class_type;

   // one classified job
   typedef struct packed {
      job_class_type cls;
      logic [31:0]   read_addr;
      logic [2:0]    err;
      logic [31:0]   fault_va;
      logic          dir_wr;
      logic [31:0]   dir_addr;
      logic [31:0]   dir_wdata;
      logic          tbl_wr;
      logic [31:0]   tbl_addr;
      logic [31:0]   tbl_wdata;
      logic [31:0]   base;
   } job_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

/* design/two_level_page_walker.sv */
// top level of the two-level page table walker
`default_nettype none

// Two-level page table walker for 32-bit addresses and 4 KiB pages. Each input
// word is either a translate request or the memory's answer to the last entry
// read; the block replies with read requests, write-backs of accessed and dirty
// bits, a done word with the page base, a fault word or a page-cross word. The
// front takes one input word every cycle as long as its two-entry job queue has
// room; the back drains jobs through the output register at one result word per
// cycle while rsp_ready holds, so a request or a directory response yields one
// result word and a completing leaf one to three, and that output rate sets the
// sustained throughput. The user must write the directory page number through
// csr_wr_en only while the block is idle; the block itself does not enforce this.
module two_level_page_walker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [19:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [31:0] req_virt_addr,
   input  wire logic [3:0]  req_access_len,
   input  wire logic [1:0]  req_access_kind,
   input  wire logic        req_user_mode,
   input  wire logic        req_locked,
   input  wire logic [31:0] req_read_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_out_kind,
   output logic [31:0]      rsp_mem_addr,
   output logic [31:0]      rsp_write_data,
   output logic [31:0]      rsp_phys_page_base,
   output logic [2:0]       rsp_fault_code,
   output logic [31:0]      rsp_fault_vaddr,
   output logic             rsp_last
);
   import ptw_pkg::*;

   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             push;
   logic             pop;

   // classify incoming words
   ptw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_virt_addr   (req_virt_addr),
      .req_access_len  (req_access_len),
      .req_access_kind (req_access_kind),
      .req_user_mode   (req_user_mode),
      .req_locked      (req_locked),
      .req_read_data   (req_read_data),
      .q_status        (q_status),
      .push            (push),
      .push_job        (push_job)
   );

   // job queue
   ptw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // result word generation
   ptw_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (head_job),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_kind       (rsp_out_kind),
      .rsp_mem_addr       (rsp_mem_addr),
      .rsp_write_data     (rsp_write_data),
      .rsp_phys_page_base (rsp_phys_page_base),
      .rsp_fault_code     (rsp_fault_code),
      .rsp_fault_vaddr    (rsp_fault_vaddr),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

/* design/ptw_front.sv */
// front part: accepts words, tracks the walk and classifies each into a job
`default_nettype none

module ptw_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [19:0]                csr_wr_data,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_op,
   input  wire logic [31:0]                req_virt_addr,
   input  wire logic [3:0]                 req_access_len,
   input  wire logic [1:0]                 req_access_kind,
   input  wire logic                       req_user_mode,
   input  wire logic                       req_locked,
   input  wire logic [31:0]                req_read_data,
   input  wire ptw_pkg::queue_status_type  q_status,
   output logic                            push,
   output ptw_pkg::job_type                push_job
);
   import ptw_pkg::*;

   logic [19:0] pdb_ff, pdb_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] saved_va_ff, saved_va_in;
   logic [1:0]  saved_kind_ff, saved_kind_in;
   logic        saved_user_ff, saved_user_in;
   logic        saved_locked_ff, saved_locked_in;
   logic [31:0] dir_addr_ff, dir_addr_in;
   logic [31:0] dir_word_ff, dir_word_in;
   logic [31:0] tbl_addr_ff, tbl_addr_in;

   logic        accept;
   logic        has_job;
   logic [12:0] end_off;
   logic        perm_write;
   logic        plain_write;
   logic        perm_bad;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && has_job;

   // page-cross test on raw length
   assign end_off = {1'b0, req_virt_addr[PageShift-1:0]} + {9'd0, req_access_len};

   // permission class of the walk in progress
   assign perm_write  = (saved_kind_ff == AccWrite) ||
                        ((saved_kind_ff == AccRead) && saved_locked_ff);
   assign plain_write = (saved_kind_ff == AccWrite);
   assign perm_bad    = (saved_user_ff && !req_read_data[BitU]) ||
                        (perm_write && !req_read_data[BitW]);

   // classify and compute next walk state
   always_comb begin
      pdb_in          = csr_wr_en ? csr_wr_data : pdb_ff;
      phase_in        = phase_ff;
      saved_va_in     = saved_va_ff;
      saved_kind_in   = saved_kind_ff;
      saved_user_in   = saved_user_ff;
      saved_locked_in = saved_locked_ff;
      dir_addr_in     = dir_addr_ff;
      dir_word_in     = dir_word_ff;
      tbl_addr_in     = tbl_addr_ff;
      has_job         = 1'b0;
      push_job        = '0;
      push_job.fault_va = saved_va_ff;
      push_job.err    = {saved_user_ff, perm_write, 1'b0};

      if (req_op == OpRequest) begin
         saved_va_in     = req_virt_addr;
         saved_kind_in   = req_access_kind;
         saved_user_in   = req_user_mode;
         saved_locked_in = req_locked;
         has_job         = 1'b1;
         if (end_off > 13'(PageSize)) begin
            phase_in     = PH_IDLE;
            push_job.cls = JOB_CROSS;
         end else begin
            dir_addr_in        = {pdb_ff, req_virt_addr[31:PageShift+VpnBits], 2'b00};
            phase_in           = PH_DIR;
            push_job.cls       = JOB_READ;
            push_job.read_addr = {pdb_ff, req_virt_addr[31:PageShift+VpnBits], 2'b00};
         end
      end else begin
         unique case (phase_ff)
            PH_DIR: begin
               has_job     = 1'b1;
               dir_word_in = req_read_data;
               if (!req_read_data[BitP]) begin
                  phase_in     = PH_IDLE;
                  push_job.cls = JOB_FAULT;
               end else begin
                  tbl_addr_in = {req_read_data[31:PageShift],
                                 saved_va_ff[PageShift+VpnBits-1:PageShift], 2'b00};
                  phase_in           = PH_TBL;
                  push_job.cls       = JOB_READ;
                  push_job.read_addr = {req_read_data[31:PageShift],
                                        saved_va_ff[PageShift+VpnBits-1:PageShift], 2'b00};
               end
            end
            PH_TBL: begin
               has_job  = 1'b1;
               phase_in = PH_IDLE;
               if (!req_read_data[BitP]) begin
                  push_job.cls = JOB_FAULT;
               end else if (perm_bad) begin
                  push_job.cls = JOB_FAULT;
                  push_job.err = {saved_user_ff, perm_write, 1'b1};
               end else begin
                  push_job.cls       = JOB_LEAF;
                  push_job.dir_wr    = !dir_word_ff[BitA];
                  push_job.dir_addr  = dir_addr_ff;
                  push_job.dir_wdata = dir_word_ff | (32'd1 << BitA);
                  push_job.tbl_wr    = !req_read_data[BitA] ||
                                       (!req_read_data[BitD] && plain_write);
                  push_job.tbl_addr  = tbl_addr_ff;
                  push_job.tbl_wdata = req_read_data | (32'd1 << BitA) |
                                       (plain_write ? (32'd1 << BitD) : 32'd0);
                  push_job.base      = {req_read_data[31:PageShift], 12'd0};
               end
            end
            PH_IDLE: begin
               has_job = 1'b0;
            end
            default: begin
               has_job = 1'b0;
            end
         endcase
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         pdb_ff <= '0;
      end else begin
         pdb_ff <= pdb_in;
      end
   end

   // walk phase
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   // saved request and entry context
   always_ff @(posedge clock) begin
      if (accept) begin
         saved_va_ff     <= saved_va_in;
         saved_kind_ff   <= saved_kind_in;
         saved_user_ff   <= saved_user_in;
         saved_locked_ff <= saved_locked_in;
         dir_addr_ff     <= dir_addr_in;
         dir_word_ff     <= dir_word_in;
         tbl_addr_ff     <= tbl_addr_in;
      end
   end

endmodule

`default_nettype wire

/* design/ptw_queue.sv */
// short job queue between the front and back parts
`default_nettype none

module ptw_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire ptw_pkg::job_type            push_job,
   input  wire logic                        pop,
   output ptw_pkg::job_type                 head_job,
   output ptw_pkg::queue_status_type        status
);
   import ptw_pkg::*;

   job_type                entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == QueueCntW'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign head_job     = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* design/ptw_back.sv */
// back part: expands each job into result words through an output register
`default_nettype none

module ptw_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ptw_pkg::job_type           head_job,
   input  wire ptw_pkg::queue_status_type  q_status,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [2:0]                      rsp_out_kind,
   output logic [31:0]                     rsp_mem_addr,
   output logic [31:0]                     rsp_write_data,
   output logic [31:0]                     rsp_phys_page_base,
   output logic [2:0]                      rsp_fault_code,
   output logic [31:0]                     rsp_fault_vaddr,
   output logic                            rsp_last
);
   import ptw_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  step_ff, step_in;
   logic [2:0]  kind_ff, kind_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] wdata_ff, wdata_in;
   logic [31:0] base_ff, base_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] fva_ff, fva_in;
   logic        last_ff, last_in;
   logic        load;

   // output register free or draining this cycle, and a job waiting
   assign load = (!valid_ff || rsp_ready) && !q_status.empty;

   // next result word of the head job
   always_comb begin
      step_in  = step_ff;
      kind_in  = KIND_DONE;
      addr_in  = '0;
      wdata_in = '0;
      base_in  = '0;
      err_in   = '0;
      fva_in   = '0;
      last_in  = 1'b1;
      pop      = 1'b0;
      if (load) begin
         unique case (head_job.cls)
            JOB_CROSS: begin
               kind_in = KIND_CROSS;
               pop     = 1'b1;
            end
            JOB_READ: begin
               kind_in = KIND_MEM_READ;
               addr_in = head_job.read_addr;
               pop     = 1'b1;
            end
            JOB_FAULT: begin
               kind_in = KIND_FAULT;
               err_in  = head_job.err;
               fva_in  = head_job.fault_va;
               pop     = 1'b1;
            end
            JOB_LEAF: begin
               if (head_job.dir_wr && step_ff == 2'd0) begin
                  kind_in  = KIND_MEM_WRITE;
                  addr_in  = head_job.dir_addr;
                  wdata_in = head_job.dir_wdata;
                  last_in  = 1'b0;
                  step_in  = 2'd1;
               end else if (head_job.tbl_wr && step_ff != 2'd2) begin
                  kind_in  = KIND_MEM_WRITE;
                  addr_in  = head_job.tbl_addr;
                  wdata_in = head_job.tbl_wdata;
                  last_in  = 1'b0;
                  step_in  = 2'd2;
               end else begin
                  kind_in = KIND_DONE;
                  base_in = head_job.base;
                  pop     = 1'b1;
                  step_in = 2'd0;
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   // output valid
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   // output word payload
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         addr_ff  <= addr_in;
         wdata_ff <= wdata_in;
         base_ff  <= base_in;
         err_ff   <= err_in;
         fva_ff   <= fva_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_kind       = kind_ff;
   assign rsp_mem_addr       = addr_ff;
   assign rsp_write_data     = wdata_ff;
   assign rsp_phys_page_base = base_ff;
   assign rsp_fault_code     = err_ff;
   assign rsp_fault_vaddr    = fva_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

/* verif/two_level_page_walker_tb.sv */
// self-checking testbench for the two-level page table walker
`timescale 1ns / 100ps

module two_level_page_walker_tb;
   import ptw_pkg::*;

   localparam int unsigned IdleLimit   = 1000;
   localparam int unsigned SettleSpan  = 12;
   localparam int unsigned PhaseWords  = 95;

   // one input word as the sender holds it
   typedef struct packed {
      logic        op;
      logic [31:0] va;
      logic [3:0]  len;
      logic [1:0]  kind;
      logic        user;
      logic        lock;
      logic [31:0] data;
   } walk_word_type;

   // one predicted result word
   typedef struct packed {
      out_kind_type kind;
      logic [31:0]  mem_addr;
      logic [31:0]  wdata;
      logic [31:0]  page_base;
      logic [2:0]   err;
      logic [31:0]  fault_va;
      logic         last;
   } walk_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [19:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_op = 1'b0;
   logic [31:0] req_virt_addr = '0;
   logic [3:0]  req_access_len = '0;
   logic [1:0]  req_access_kind = '0;
   logic        req_user_mode = 1'b0;
   logic        req_locked = 1'b0;
   logic [31:0] req_read_data = '0;
   logic        rsp_ready = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [2:0]  rsp_out_kind;
   logic [31:0] rsp_mem_addr;
   logic [31:0] rsp_write_data;
   logic [31:0] rsp_phys_page_base;
   logic [2:0]  rsp_fault_code;
   logic [31:0] rsp_fault_vaddr;
   logic        rsp_last;

   two_level_page_walker uut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_virt_addr      (req_virt_addr),
      .req_access_len     (req_access_len),
      .req_access_kind    (req_access_kind),
      .req_user_mode      (req_user_mode),
      .req_locked         (req_locked),
      .req_read_data      (req_read_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_kind       (rsp_out_kind),
      .rsp_mem_addr       (rsp_mem_addr),
      .rsp_write_data     (rsp_write_data),
      .rsp_phys_page_base (rsp_phys_page_base),
      .rsp_fault_code     (rsp_fault_code),
      .rsp_fault_vaddr    (rsp_fault_vaddr),
      .rsp_last           (rsp_last)
   );

   always #5 clock = ~clock;

   // stimulus and scoreboard storage
   walk_word_type   pending_words[$];
   walk_result_type walk_results_due[$];
   int unsigned  words_issued = 0;
   int unsigned  words_accepted = 0;
   int unsigned  words_queued = 0;
   int unsigned  results_checked = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  done_seen = 0, fault_seen = 0, cross_seen = 0;
   int unsigned  writeback_seen = 0, entry_reads_seen = 0;

   // walker state as predicted
   logic [19:0]  dir_base_m;
   phase_type    walk_phase_m;
   logic [31:0]  walk_va_m;
   logic [1:0]   walk_kind_m;
   logic         walk_user_m;
   logic         walk_lock_m;
   logic [31:0]  dir_addr_m;
   logic [31:0]  dir_word_m;
   logic [31:0]  tbl_addr_m;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic push_result(input out_kind_type kind, input logic [31:0] addr,
                              input logic [31:0] wdata, input logic [31:0] base,
                              input logic [2:0] err, input logic [31:0] fva,
                              input logic last);
      walk_result_type r;
      r.kind      = kind;
      r.mem_addr  = addr;
      r.wdata     = wdata;
      r.page_base = base;
      r.err       = err;
      r.fault_va  = fva;
      r.last      = last;
      walk_results_due.push_back(r);
   endtask

   // a locked read is treated as a write by the permission check
   function automatic logic walk_counts_as_write();
      return walk_kind_m == AccWrite || (walk_kind_m == AccRead && walk_lock_m);
   endfunction

   task automatic push_fault(input logic present);
      push_result(KIND_FAULT, '0, '0, '0, {walk_user_m, walk_counts_as_write(), present},
                  walk_va_m, 1'b1);
      walk_phase_m = PH_IDLE;
   endtask

   // expected result words for one accepted input word
   task automatic predict_walk(input walk_word_type w);
      logic plain_write;
      logic [31:0] ent;
      ent = w.data;
      if (w.op == OpRequest) begin
         walk_va_m   = w.va;
         walk_kind_m = w.kind;
         walk_user_m = w.user;
         walk_lock_m = w.lock;
         if (int'(w.va[11:0]) + int'(w.len) > int'(PageSize)) begin
            walk_phase_m = PH_IDLE;
            push_result(KIND_CROSS, '0, '0, '0, '0, '0, 1'b1);
         end else begin
            dir_addr_m   = {dir_base_m, w.va[31:22], 2'b00};
            walk_phase_m = PH_DIR;
            push_result(KIND_MEM_READ, dir_addr_m, '0, '0, '0, '0, 1'b1);
         end
      end else if (walk_phase_m == PH_DIR) begin
         dir_word_m = ent;
         if (!ent[BitP]) begin
            push_fault(1'b0);
         end else begin
            tbl_addr_m   = {ent[31:12], walk_va_m[21:12], 2'b00};
            walk_phase_m = PH_TBL;
            push_result(KIND_MEM_READ, tbl_addr_m, '0, '0, '0, '0, 1'b1);
         end
      end else if (walk_phase_m == PH_TBL) begin
         plain_write = walk_kind_m == AccWrite;
         if (!ent[BitP]) begin
            push_fault(1'b0);
         end else if ((walk_user_m && !ent[BitU]) || (walk_counts_as_write() && !ent[BitW])) begin
            push_fault(1'b1);
         end else begin
            // accessed and dirty write-backs, then the page base
            if (!dir_word_m[BitA]) begin
               push_result(KIND_MEM_WRITE, dir_addr_m, dir_word_m | (32'd1 << BitA),
                           '0, '0, '0, 1'b0);
            end
            if (!ent[BitA] || (!ent[BitD] && plain_write)) begin
               push_result(KIND_MEM_WRITE, tbl_addr_m,
                           ent | (32'd1 << BitA) | (plain_write ? (32'd1 << BitD) : 32'd0),
                           '0, '0, '0, 1'b0);
            end
            push_result(KIND_DONE, '0, '0, {ent[31:12], 12'h000}, '0, '0, 1'b1);
            walk_phase_m = PH_IDLE;
         end
      end
   endtask

   // monitor: predict on accepted input words, check accepted result words
   always @(posedge clock) begin
      walk_word_type   w;
      walk_result_type e;
      if (reset) begin
         dir_base_m   = '0;
         walk_phase_m = PH_IDLE;
         walk_va_m    = '0;
         walk_kind_m  = '0;
         walk_user_m  = 1'b0;
         walk_lock_m  = 1'b0;
         dir_addr_m   = '0;
         dir_word_m   = '0;
         tbl_addr_m   = '0;
      end else begin
         if (csr_wr_en) dir_base_m = csr_wr_data;
         if (req_valid && req_ready) begin
            w = {req_op, req_virt_addr, req_access_len, req_access_kind,
                 req_user_mode, req_locked, req_read_data};
            predict_walk(w);
            words_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (walk_results_due.size() == 0) begin
               report_mismatch($sformatf("result word with none expected, kind %0d",
                                         rsp_out_kind));
            end else begin
               e = walk_results_due.pop_front();
               results_checked++;
               if (rsp_out_kind !== e.kind)
                  report_mismatch($sformatf("out_kind %0d, expected %0d", rsp_out_kind, e.kind));
               if (rsp_mem_addr !== e.mem_addr)
                  report_mismatch($sformatf("mem_addr %h, expected %h", rsp_mem_addr, e.mem_addr));
               if (rsp_write_data !== e.wdata)
                  report_mismatch($sformatf("write_data %h, expected %h",
                                            rsp_write_data, e.wdata));
               if (rsp_phys_page_base !== e.page_base)
                  report_mismatch($sformatf("phys_page_base %h, expected %h",
                                            rsp_phys_page_base, e.page_base));
               if (rsp_fault_code !== e.err)
                  report_mismatch($sformatf("fault_code %b, expected %b", rsp_fault_code, e.err));
               if (rsp_fault_vaddr !== e.fault_va)
                  report_mismatch($sformatf("fault_vaddr %h, expected %h",
                                            rsp_fault_vaddr, e.fault_va));
               if (rsp_last !== e.last)
                  report_mismatch($sformatf("last %b, expected %b", rsp_last, e.last));
               case (e.kind)
                  KIND_DONE:      done_seen++;
                  KIND_FAULT:     fault_seen++;
                  KIND_CROSS:     cross_seen++;
                  KIND_MEM_WRITE: writeback_seen++;
                  default:        entry_reads_seen++;
               endcase
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   int unsigned idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
         $display("timeout: no word moved for %0d cycles", IdleLimit);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // driver: bursts of words from the pending queue, random gaps between bursts
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   walk_word_type cur_word = '0;
   always @(negedge clock) begin
      logic nxt_valid;
      nxt_valid = req_valid;
      if (!reset && words_accepted == words_issued) begin
         nxt_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_words.size() > 0) begin
            cur_word = pending_words.pop_front();
            nxt_valid = 1'b1;
            words_issued++;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
      req_valid       <= nxt_valid;
      req_op          <= cur_word.op;
      req_virt_addr   <= cur_word.va;
      req_access_len  <= cur_word.len;
      req_access_kind <= cur_word.kind;
      req_user_mode   <= cur_word.user;
      req_locked      <= cur_word.lock;
      req_read_data   <= cur_word.data;
   end

   // receiver: ready follows a rotating pattern that is redrawn when its random span runs out
   logic [15:0] stall_pattern = 16'hffff;
   bit   [3:0]  stall_pos = 0;
   int unsigned stall_span = 0;
   always @(negedge clock) begin
      if (stall_span == 0) begin
         case ($urandom_range(0, 2))
            0:       stall_pattern = 16'hffff;
            1:       stall_pattern = 16'($urandom);
            default: stall_pattern = 16'($urandom & $urandom & $urandom);
         endcase
         stall_pattern[$urandom_range(0, 15)] = 1'b1;
         stall_span = $urandom_range(16, 96);
      end else begin
         stall_span--;
      end
      rsp_ready <= stall_pattern[stall_pos];
      stall_pos++;
   end

   // word builders
   function automatic walk_word_type make_request(input logic [31:0] va, input logic [3:0] len,
                                                  input logic [1:0] kind, input logic user,
                                                  input logic lock);
      walk_word_type w;
      w.op   = OpRequest;
      w.va   = va;
      w.len  = len;
      w.kind = kind;
      w.user = user;
      w.lock = lock;
      w.data = $urandom;
      return w;
   endfunction

   function automatic walk_word_type make_response(input logic [31:0] data);
      walk_word_type w;
      w      = make_request($urandom, 4'($urandom), 2'($urandom), 1'($urandom),
                            1'($urandom));
      w.op   = OpResponse;
      w.data = data;
      return w;
   endfunction

   function automatic walk_word_type random_request(input bit crossing);
      int unsigned len, off;
      logic [31:0] va;
      if (crossing) begin
         len = $urandom_range(2, 15);
         off = $urandom_range(PageSize + 1 - len, PageSize - 1);
      end else begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         if ($urandom_range(0, 7) == 0)
            off = (len == 0) ? PageSize - 1 : PageSize - len;
         else
            off = $urandom_range(0, (len == 0) ? PageSize - 1 : PageSize - len);
      end
      va = $urandom;
      va[11:0] = off[11:0];
      return make_request(va, len[3:0], 2'($urandom_range(0, 3)), 1'($urandom),
                          1'($urandom));
   endfunction

   // entry word with random content, mostly present and permissive
   function automatic logic [31:0] random_entry();
      logic [31:0] ent;
      ent = $urandom;
      ent[BitP] = $urandom_range(0, 9) != 0;
      ent[BitW] = $urandom_range(0, 3) != 0;
      ent[BitU] = $urandom_range(0, 3) != 0;
      return ent;
   endfunction

   task automatic queue_word(input walk_word_type w, input bit counted);
      pending_words.push_back(w);
      if (counted) words_queued++;
   endtask

   // corner cases: page edges, every access kind, faults at both levels
   task automatic queue_directed();
      queue_word(make_request(32'h0000_0000, 4'd1, AccFetch, 1'b0, 1'b0), 1);
      queue_word(make_response(32'h0000_0001), 1);
      queue_word(make_response(32'h0000_0007), 1);
      queue_word(make_request(32'hffff_ffff, 4'd1, AccWrite, 1'b1, 1'b0), 1);
      queue_word(make_response(32'hffff_ffff), 1);
      queue_word(make_response(32'hffff_ffff), 1);
      queue_word(make_request(32'h0000_0fff, 4'd2, AccRead, 1'b0, 1'b0), 1);
      // locked read, directory entry missing
      queue_word(make_request(32'h0000_0ff8, 4'd8, AccRead, 1'b1, 1'b1), 1);
      queue_word(make_response(32'h0000_0000), 1);
      // zero length, access kind three, leaf missing
      queue_word(make_request(32'h1234_5678, 4'd0, 2'd3, 1'b0, 1'b0), 1);
      queue_word(make_response(32'habcd_e021), 1);
      queue_word(make_response(32'hffff_fffe), 1);
      // user access to a supervisor page
      queue_word(make_request(32'h8000_0000, 4'd15, AccWrite, 1'b1, 1'b0), 1);
      queue_word(make_response(32'h0000_0023), 1);
      queue_word(make_response(32'h0000_1003), 1);
      // locked read to a read-only page
      queue_word(make_request(32'h7fff_f000, 4'd4, AccRead, 1'b0, 1'b1), 1);
      queue_word(make_response(32'h0000_0001), 1);
      queue_word(make_response(32'h0000_2005), 1);
      // response with no walk open
      queue_word(make_response(32'h5555_5555), 0);
      // new request drops the open walk, then a write sets dirty only
      queue_word(make_request(32'h0040_0000, 4'd4, AccRead, 1'b0, 1'b0), 1);
      queue_word(make_request(32'h0040_1000, 4'd4, AccWrite, 1'b0, 1'b0), 1);
      queue_word(make_response(32'h0000_3021), 1);
      queue_word(make_response(32'h0000_4027), 1);
      queue_word(make_request(32'h0000_0ff2, 4'd15, AccFetch, 1'b0, 1'b0), 1);
   endtask

   // mostly complete walks with random content, the rest broken walks and noise
   task automatic queue_random(input int unsigned count);
      int unsigned goal, pick;
      logic [31:0] ent;
      goal = words_queued + count;
      while (words_queued < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            queue_word(random_request(1'b0), 1);
            queue_word(make_response(random_entry()), 1);
            queue_word(make_response(random_entry()), 1);
         end else if (pick < 70) begin
            queue_word(random_request(1'b0), 1);
         end else if (pick < 78) begin
            queue_word(random_request(1'b0), 1);
            queue_word(make_response(random_entry()), 1);
         end else if (pick < 88) begin
            queue_word(random_request(1'b1), 1);
         end else if (pick < 94) begin
            ent = $urandom;
            queue_word(make_response(ent), 0);
         end else begin
            queue_word(($urandom_range(0, 1) == 0) ? random_request($urandom_range(0, 1))
                                                   : make_response($urandom), 1);
         end
      end
      // a page-cross request leaves the walker idle for the next setting
      queue_word(random_request(1'b1), 1);
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || words_issued != words_accepted ||
             walk_results_due.size() != 0)
         @(posedge clock);
      repeat (SettleSpan) @(posedge clock);
   endtask

   // phases: one directory base each, extremes first
   initial begin
      logic [19:0] dir_bases[4];
      dir_bases[0] = 20'h00000;
      dir_bases[1] = 20'hfffff;
      dir_bases[2] = 20'($urandom);
      dir_bases[3] = 20'($urandom);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 4; p++) begin
         @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= dir_bases[p];
         @(negedge clock);
         csr_wr_en   <= 1'b0;
         if (p == 0) queue_directed();
         queue_random(PhaseWords);
         wait_drained();
      end
      $display("covered %0d input words under 4 directory bases, %0d result words checked",
               words_accepted, results_checked);
      $display("results: %0d entry reads, %0d write-backs, %0d done, %0d faults, %0d cross",
               entry_reads_seen, writeback_seen, done_seen, fault_seen, cross_seen);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
design/ptw_pkg.sv
design/ptw_front.sv
design/ptw_queue.sv
design/ptw_back.sv
design/two_level_page_walker.sv
verif/two_level_page_walker_tb.sv
